### rtl/cbfp_pkg.sv
// Package for the camera block frame parser.
// Types, constants and register indexes shared by all modules; no dependencies.
package cbfp_pkg;

  // Largest block limit per frame; the limit taken from the max_blocks register is capped at this.
  localparam logic [7:0] MAX_FRAME_BLOCKS = 8'd128;

  // Default depth of the command queue between front and back.
  localparam int CMD_DEPTH = 4;

  // Field words per block.
  localparam logic [2:0] FIELDS_NORMAL = 3'd5;
  localparam logic [2:0] FIELDS_CC     = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_MAX_BLOCKS   = 8'd128;
  localparam logic [15:0] RST_SYNC_WORD    = 16'haa55;
  localparam logic [15:0] RST_SYNC_WORD_CC = 16'haa56;
  localparam logic [15:0] RST_SYNC_SWAPPED = 16'h55aa;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_BLOCKS   = 2'd0,
    REG_SYNC_WORD    = 2'd1,
    REG_SYNC_WORD_CC = 2'd2,
    REG_SYNC_SWAPPED = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  max_blocks;
    logic [15:0] sync_word;
    logic [15:0] sync_word_cc;
    logic [15:0] sync_word_swapped;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_STORE      = 2'd0,  // write one field word
    CMD_STORE_EMIT = 2'd1,  // write the last field word and emit the block
    CMD_FRAME_END  = 2'd2   // emit a frame end
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  idx;
    logic [15:0] word;
    logic        cc;
    logic        ok;
    logic [7:0]  count;
  } cmd_t;

endpackage

### rtl/cbfp_front.sv
// Front end of the camera block frame parser: byte pairing, sync hunt,
// checksum and block tally. Emits commands for the back end. Uses cbfp_pkg.
module cbfp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_take,
  input  logic [7:0]    data_byte,
  input  cbfp_pkg::cfg_t cfg,
  output logic          cmd_push,
  output cbfp_pkg::cmd_t cmd
);
  import cbfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_DROP   = 3'd1,
    PH_CSUM   = 3'd2,
    PH_FIELDS = 3'd3,
    PH_TRAIL  = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic        byte_hi, byte_hi_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] prev_word, prev_word_next;
  logic [2:0]  field_idx, field_idx_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] expected_sum, expected_sum_next;
  logic        cc_mode, cc_mode_next;
  logic [7:0]  tally, tally_next;

  logic [15:0] word;
  logic [15:0] sum_add;
  logic [2:0]  idx_inc;
  logic [2:0]  n_fields;
  logic [7:0]  mb_min1;
  logic [7:0]  limit;
  logic        sum_ok;

  assign word     = {data_byte, low_byte};
  assign sum_add  = running_sum + word;
  assign idx_inc  = field_idx + 3'd1;
  assign n_fields = cc_mode ? FIELDS_CC : FIELDS_NORMAL;
  assign sum_ok   = (sum_add == expected_sum);
  assign mb_min1  = (cfg.max_blocks == 8'd0) ? 8'd1 : cfg.max_blocks;
  assign limit    = (mb_min1 > MAX_FRAME_BLOCKS) ? MAX_FRAME_BLOCKS : mb_min1;

  always_comb begin
    phase_next        = phase;
    byte_hi_next      = byte_hi;
    low_byte_next     = low_byte;
    prev_word_next    = prev_word;
    field_idx_next    = field_idx;
    running_sum_next  = running_sum;
    expected_sum_next = expected_sum;
    cc_mode_next      = cc_mode;
    tally_next        = tally;
    cmd_push          = 1'b0;
    cmd.kind          = CMD_FRAME_END;
    cmd.idx           = field_idx;
    cmd.word          = word;
    cmd.cc            = cc_mode;
    cmd.ok            = sum_ok;
    cmd.count         = tally;

    if (byte_take) begin
      if (phase == PH_DROP) begin
        phase_next = PH_HUNT;            // realign: byte discarded
      end else if (!byte_hi) begin
        low_byte_next = data_byte;
        byte_hi_next  = 1'b1;
      end else begin
        byte_hi_next = 1'b0;
        case (phase)
          PH_CSUM: begin
            if (word == cfg.sync_word) begin
              cc_mode_next = 1'b0;
              cmd_push     = 1'b1;
              tally_next   = 8'd0;
            end else if (word == cfg.sync_word_cc) begin
              cc_mode_next = 1'b1;
              cmd_push     = 1'b1;
              tally_next   = 8'd0;
            end else if (word == 16'd0) begin
              phase_next     = PH_HUNT;
              prev_word_next = 16'hffff;
              cmd_push       = 1'b1;
              tally_next     = 8'd0;
            end else begin
              expected_sum_next = word;
              running_sum_next  = 16'd0;
              field_idx_next    = 3'd0;
              phase_next        = PH_FIELDS;
            end
          end
          PH_FIELDS: begin
            cmd_push = 1'b1;
            if (idx_inc == n_fields) begin
              cmd.kind       = CMD_STORE_EMIT;
              tally_next     = tally + {7'd0, sum_ok};
              field_idx_next = 3'd0;
              phase_next     = PH_TRAIL;
            end else begin
              cmd.kind         = CMD_STORE;
              running_sum_next = sum_add;
              field_idx_next   = idx_inc;
            end
          end
          PH_TRAIL: begin
            if (word == cfg.sync_word || word == cfg.sync_word_cc) begin
              cc_mode_next = (word != cfg.sync_word);
              if (tally >= limit) begin
                phase_next     = PH_HUNT;
                prev_word_next = 16'hffff;
                cmd_push       = 1'b1;
                tally_next     = 8'd0;
              end else begin
                phase_next = PH_CSUM;
              end
            end else begin
              phase_next     = PH_HUNT;
              prev_word_next = 16'hffff;
              cmd_push       = 1'b1;
              tally_next     = 8'd0;
            end
          end
          default: begin                 // hunt
            phase_next = PH_HUNT;
            if (word == 16'd0 && prev_word == 16'd0) begin
              prev_word_next = 16'hffff;
              tally_next     = 8'd0;
              cmd_push       = 1'b1;
              cmd.count      = 8'd0;
            end else if (word == cfg.sync_word && prev_word == cfg.sync_word) begin
              cc_mode_next = 1'b0;
              tally_next   = 8'd0;
              phase_next   = PH_CSUM;
            end else if (word == cfg.sync_word_cc && prev_word == cfg.sync_word) begin
              cc_mode_next = 1'b1;
              tally_next   = 8'd0;
              phase_next   = PH_CSUM;
            end else begin
              if (word == cfg.sync_word_swapped) phase_next = PH_DROP;
              prev_word_next = word;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_hi      <= 1'b0;
      low_byte     <= 8'd0;
      prev_word    <= 16'hffff;
      field_idx    <= 3'd0;
      running_sum  <= 16'd0;
      expected_sum <= 16'd0;
      cc_mode      <= 1'b0;
      tally        <= 8'd0;
    end else begin
      phase        <= phase_next;
      byte_hi      <= byte_hi_next;
      low_byte     <= low_byte_next;
      prev_word    <= prev_word_next;
      field_idx    <= field_idx_next;
      running_sum  <= running_sum_next;
      expected_sum <= expected_sum_next;
      cc_mode      <= cc_mode_next;
      tally        <= tally_next;
    end
  end

  // field index stays inside the six-entry store
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FIELDS |-> field_idx < FIELDS_CC)
    else $error("field index out of range");

  // a dropped byte returns to the hunt and changes no pairing state
  a_drop: assert property (@(posedge clk) disable iff (rst)
    byte_take && phase == PH_DROP |=> phase == PH_HUNT && $stable(byte_hi))
    else $error("drop byte mishandled");

  // tally never exceeds the hard block cap
  a_tally: assert property (@(posedge clk) disable iff (rst)
    tally <= MAX_FRAME_BLOCKS)
    else $error("block tally over cap");

endmodule

### rtl/cbfp_cmd_fifo.sv
// Command queue between front and back of the camera block frame parser.
// Small register FIFO of cmd_t entries. Uses cbfp_pkg.
module cbfp_cmd_fifo #(
  parameter int DEPTH = cbfp_pkg::CMD_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  cbfp_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output cbfp_pkg::cmd_t rd_data,
  output logic           nonempty
);
  import cbfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_wr && !do_rd) count <= count + CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - CNT_W'(1);
    end
  end

  // the front is held off while the queue is full, so no command is lost
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command queue overflow");

endmodule

### rtl/cbfp_back.sv
// Back end of the camera block frame parser: field store and result register.
// Executes commands from the queue. Uses cbfp_pkg.
module cbfp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  cbfp_pkg::cmd_t cmd,
  output logic           cmd_take,
  input  logic           pop,
  output logic           empty,
  output logic           result_kind,
  output logic [15:0]    signature,
  output logic [15:0]    pos_x,
  output logic [15:0]    pos_y,
  output logic [15:0]    box_width,
  output logic [15:0]    box_height,
  output logic [15:0]    box_angle,
  output logic           color_code,
  output logic           checksum_ok,
  output logic [7:0]     good_count
);
  import cbfp_pkg::*;

  logic [15:0] store [6];
  logic [15:0] fld   [6];
  logic        out_valid;
  logic        slot_free;
  logic        emits;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign emits     = (cmd.kind == CMD_STORE_EMIT) || (cmd.kind == CMD_FRAME_END);
  assign cmd_take  = cmd_valid && (!emits || slot_free);

  // fields as they stand with this beat's word written in
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      fld[i] = (cmd.idx == 3'(i)) ? cmd.word : store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && (cmd.kind == CMD_STORE || cmd.kind == CMD_STORE_EMIT)) begin
      for (int i = 0; i < 6; i++) begin
        if (cmd.idx == 3'(i)) store[i] <= cmd.word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd_take && emits) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      unique case (cmd.kind)
        CMD_STORE_EMIT: begin
          result_kind <= 1'b0;
          signature   <= fld[0];
          pos_x       <= fld[1];
          pos_y       <= fld[2];
          box_width   <= fld[3];
          box_height  <= fld[4];
          box_angle   <= cmd.cc ? fld[5] : 16'd0;
          color_code  <= cmd.cc;
          checksum_ok <= cmd.ok;
          good_count  <= 8'd0;
        end
        CMD_FRAME_END: begin
          result_kind <= 1'b1;
          signature   <= 16'd0;
          pos_x       <= 16'd0;
          pos_y       <= 16'd0;
          box_width   <= 16'd0;
          box_height  <= 16'd0;
          box_angle   <= 16'd0;
          color_code  <= 1'b0;
          checksum_ok <= 1'b0;
          good_count  <= cmd.count;
        end
        default: begin
        end
      endcase
    end
  end

  // a frame end carries only its count
  a_frame_end_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind |-> signature == 16'd0 && color_code == 1'b0
      && checksum_ok == 1'b0)
    else $error("frame end with block fields");

  // a block result carries no count
  a_block_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind |-> good_count == 8'd0)
    else $error("block result with count");

endmodule

### rtl/camera_block_frame_parser_top.sv
// Top level of the camera block frame parser.
// Instantiates cbfp_front, cbfp_cmd_fifo and cbfp_back; uses cbfp_pkg.
//
//  channel   direction  handshake                     beat
//  -------   ---------  ----------------------------  -------------------------
//  input     in         push, full                    data_byte
//  result    out        empty, pop                    result_kind .. good_count
//  config    in         cfg_valid, cfg_ready (=1)     cfg_index, cfg_data
//
// One input beat per cycle while full is low. The front turns an accepted byte into
// at most one command at the same edge; the back takes it from the queue and
// registers any result, an emitting command waiting for a free or popped result register.
// full rises only when the command queue is full, which happens only while the
// result register waits to be popped. Reset is synchronous; the parser starts
// in the sync hunt with the default registers.
module camera_block_frame_parser_top #(
  parameter int CMD_DEPTH = cbfp_pkg::CMD_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // input bytes
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         data_byte,
  // results
  output logic                               empty,
  input  logic                               pop,
  output logic                               result_kind,
  output logic [15:0]                        signature,
  output logic [15:0]                        pos_x,
  output logic [15:0]                        pos_y,
  output logic [15:0]                        box_width,
  output logic [15:0]                        box_height,
  output logic [15:0]                        box_angle,
  output logic                               color_code,
  output logic                               checksum_ok,
  output logic [7:0]                         good_count,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cbfp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cbfp_pkg::*;

  cfg_t cfg;
  logic byte_take;
  logic cmd_push, cmd_take, cmd_nonempty;
  cmd_t cmd_in, cmd_out;

  // Register writes are always taken; the user writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_blocks        <= RST_MAX_BLOCKS;
      cfg.sync_word         <= RST_SYNC_WORD;
      cfg.sync_word_cc      <= RST_SYNC_WORD_CC;
      cfg.sync_word_swapped <= RST_SYNC_SWAPPED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_BLOCKS:   cfg.max_blocks        <= cfg_data[7:0];
        REG_SYNC_WORD:    cfg.sync_word         <= cfg_data;
        REG_SYNC_WORD_CC: cfg.sync_word_cc      <= cfg_data;
        REG_SYNC_SWAPPED: cfg.sync_word_swapped <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Every accepted byte produces at most one command, so a free queue slot
  // is all the front needs.
  assign byte_take = push && !full;

  cbfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .data_byte (data_byte),
    .cfg       (cfg),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  cbfp_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_push),
    .wr_data  (cmd_in),
    .full     (full),
    .rd_en    (cmd_take),
    .rd_data  (cmd_out),
    .nonempty (cmd_nonempty)
  );

  // Back end: field words go straight to the store; emitting commands wait
  // for the result register to be free or popped in the same cycle.
  cbfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_nonempty),
    .cmd         (cmd_out),
    .cmd_take    (cmd_take),
    .pop         (pop),
    .empty       (empty),
    .result_kind (result_kind),
    .signature   (signature),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .box_angle   (box_angle),
    .color_code  (color_code),
    .checksum_ok (checksum_ok),
    .good_count  (good_count)
  );

endmodule

### sim/camera_block_frame_parser_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for camera_block_frame_parser_top: byte stream in, parsed
// blocks and frame ends out, checked in order against an in-bench parser model.
// Depends on cbfp_pkg and the camera_block_frame_parser_top RTL.
module camera_block_frame_parser_top_test;
  import cbfp_pkg::*;

  // A cycle with no beat on any channel counts toward this; generous vs. the
  // longest gap, the longest pop stall and the post-drain settle.
  localparam int IDLE_LIMIT        = 2000;
  // Word commands may still sit in front/queue after the last result pops.
  localparam int SETTLE_CYCLES     = 8;
  // Running input byte count after which no new random frame starts, directed rows included.
  localparam int RANDOM_ITEMS      = 1850;
  localparam int PHASES            = 6;

  localparam logic KIND_BLOCK     = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    ST_HUNT, ST_DROP, ST_CSUM, ST_FIELDS, ST_TRAIL
  } parse_state_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] sig;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] angle;
    logic        cc;
    logic        ok;
    logic [7:0]  count;
  } parse_rec_t;

  // one row of the directed table: a byte, and optionally a hand-typed result
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    parse_rec_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        result_kind;
  logic [15:0] signature, pos_x, pos_y, box_width, box_height, box_angle;
  logic        color_code, checksum_ok;
  logic [7:0]  good_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  camera_block_frame_parser_top uut (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model: own copy of the registers and of the parse state.
  // ---------------------------------------------------------------------------
  parse_state_t st;
  logic [7:0]   lo_byte;
  logic         hi_next;      // next byte is the high half of a word
  logic [15:0]  last_word;    // previous word seen while hunting
  logic [2:0]   fld_idx;
  logic [15:0]  fld [6];
  logic [15:0]  acc_sum, csum_word;
  logic         cc_mode;
  logic [7:0]   good_tally;
  logic [7:0]   cfg_max;
  logic [15:0]  cfg_sync, cfg_sync_cc, cfg_swap;

  parse_rec_t pending_results[$];
  dir_row_t   dir_rows[$];
  int         errors = 0;
  int         bytes_sent = 0;
  bit         calm_tx = 1'b0, calm_rx = 1'b0;

  function automatic parse_rec_t mk_end(input logic [7:0] count);
    parse_rec_t r;
    r = '0;
    r.kind = KIND_FRAME_END;
    r.count = count;
    return r;
  endfunction

  function automatic parse_rec_t mk_block(input logic [15:0] sig, x, y, w, h, angle,
                                          input logic cc, ok);
    parse_rec_t r;
    r = '0;
    r.kind = KIND_BLOCK;
    r.sig = sig;
    r.x = x;
    r.y = y;
    r.w = w;
    r.h = h;
    r.angle = angle;
    r.cc = cc;
    r.ok = ok;
    return r;
  endfunction

  function automatic parse_rec_t close_frame();
    parse_rec_t r;
    r = mk_end(good_tally);
    good_tally = '0;
    return r;
  endfunction

  // Feed one accepted byte; returns 1 with the record when it produces a result.
  function automatic bit parse_byte(input logic [7:0] b, output parse_rec_t r);
    logic [15:0] w;
    int lim;
    r = '0;
    // byte thrown away after a swapped start word, to realign the pairing
    if (st == ST_DROP) begin
      st = ST_HUNT;
      return 0;
    end
    if (!hi_next) begin
      lo_byte = b;
      hi_next = 1'b1;
      return 0;
    end
    hi_next = 1'b0;
    w = {b, lo_byte};
    case (st)
      ST_CSUM: begin
        // start word where the checksum belongs: close frame, stay in checksum
        if (w == cfg_sync) begin
          cc_mode = 1'b0;
          r = close_frame();
          return 1;
        end
        if (w == cfg_sync_cc) begin
          cc_mode = 1'b1;
          r = close_frame();
          return 1;
        end
        if (w == 16'h0000) begin
          st = ST_HUNT;
          last_word = 16'hffff;
          r = close_frame();
          return 1;
        end
        csum_word = w;
        acc_sum = '0;
        fld_idx = '0;
        st = ST_FIELDS;
        return 0;
      end
      ST_FIELDS: begin
        fld[fld_idx] = w;
        acc_sum = acc_sum + w;
        fld_idx = fld_idx + 3'd1;
        if (fld_idx < (cc_mode ? FIELDS_CC : FIELDS_NORMAL)) return 0;
        if (acc_sum == csum_word) good_tally = good_tally + 8'd1;
        r = mk_block(fld[0], fld[1], fld[2], fld[3], fld[4],
                     cc_mode ? fld[5] : 16'h0000, cc_mode, acc_sum == csum_word);
        fld_idx = '0;
        st = ST_TRAIL;
        return 1;
      end
      ST_TRAIL: begin
        if (w == cfg_sync) cc_mode = 1'b0;
        else if (w == cfg_sync_cc) cc_mode = 1'b1;
        else begin
          st = ST_HUNT;
          last_word = 16'hffff;
          r = close_frame();
          return 1;
        end
        // limit only checked when chaining; 0 means 1, capped at the package max
        lim = (cfg_max == 8'd0) ? 1 : int'(cfg_max);
        if (lim > int'(MAX_FRAME_BLOCKS)) lim = int'(MAX_FRAME_BLOCKS);
        if (int'(good_tally) >= lim) begin
          st = ST_HUNT;
          last_word = 16'hffff;
          r = close_frame();
          return 1;
        end
        st = ST_CSUM;
        return 0;
      end
      default: begin
        // hunt: zero pair first, then sync pair, then sync + colour sync, then swap
        st = ST_HUNT;
        if (w == 16'h0000 && last_word == 16'h0000) begin
          last_word = 16'hffff;
          good_tally = '0;
          r = close_frame();
          return 1;
        end
        if (w == cfg_sync && last_word == cfg_sync) begin
          cc_mode = 1'b0;
          good_tally = '0;
          st = ST_CSUM;
          return 0;
        end
        if (w == cfg_sync_cc && last_word == cfg_sync) begin
          cc_mode = 1'b1;
          good_tally = '0;
          st = ST_CSUM;
          return 0;
        end
        if (w == cfg_swap) st = ST_DROP;
        last_word = w;
        return 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Field words lean toward the extremes.
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic typed = 1'b0,
                                  input parse_rec_t want = '0);
    dir_row_t r;
    r.b = b;
    r.typed = typed;
    r.want = want;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_word(input logic [15:0] w, input logic typed = 1'b0,
                                   input parse_rec_t want = '0);
    add_row(w[7:0]);
    add_row(w[15:8], typed, want);
  endfunction

  // Push one byte beat. push stays high between back-to-back beats.
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input parse_rec_t want = '0);
    int gap;
    bit has;
    parse_rec_t got;
    gap = pick_gap(calm_tx);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    has = parse_byte(b, got);
    if (typed) pending_results.insert(pending_results.size(), want);
    else if (has) pending_results.insert(pending_results.size(), got);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  // Hold off the sender until every expected result has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic go_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAX_BLOCKS:   cfg_max = val[7:0];
      REG_SYNC_WORD:    cfg_sync = val;
      REG_SYNC_WORD_CC: cfg_sync_cc = val;
      REG_SYNC_SWAPPED: cfg_swap = val;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] max_blk, input logic [15:0] sync,
                            input logic [15:0] sync_cc, input logic [15:0] swapped);
    go_idle();
    write_reg(REG_MAX_BLOCKS, max_blk);
    write_reg(REG_SYNC_WORD, sync);
    write_reg(REG_SYNC_WORD_CC, sync_cc);
    write_reg(REG_SYNC_SWAPPED, swapped);
  endtask

  // Checksum word then 5 or 6 fields; a bad block gets a checksum off by a nonzero amount.
  task automatic send_block(input bit cc, input bit bad);
    logic [15:0] f [6];
    logic [15:0] sum;
    int n;
    n = cc ? 6 : 5;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      f[i] = pick_field();
      sum = sum + f[i];
    end
    if (bad) sum = sum + 16'($urandom_range(1, 65535));
    send_word(sum);
    for (int i = 0; i < n; i++) send_word(f[i]);
  endtask

  // A frame with random content and a random ending, or now and then a zero pair.
  task automatic send_frame(input int nblk, input bit clean);
    bit cc;
    if (!clean && $urandom_range(0, 9) == 0) begin
      send_word(16'h0000);
      send_word(16'h0000);
      return;
    end
    cc = $urandom_range(0, 1);
    send_word(cfg_sync);
    send_word(cc ? cfg_sync_cc : cfg_sync);
    for (int k = 0; k < nblk; k++) begin
      if (k > 0) begin
        cc = $urandom_range(0, 1);
        send_word(cc ? cfg_sync_cc : cfg_sync);
      end
      send_block(cc, !clean && $urandom_range(0, 7) == 0);
    end
    case ($urandom_range(0, 9))
      0: begin
        // chain, then a start word as checksum, then a block read without hunting
        send_word(cfg_sync);
        cc = $urandom_range(0, 1);
        send_word(cc ? cfg_sync_cc : cfg_sync);
        send_block(cc, 1'b0);
        send_word(16'($urandom));
      end
      1: begin
        // chain, then zero as checksum
        send_word(cfg_sync);
        send_word(16'h0000);
      end
      default: send_word(16'($urandom));
    endcase
  endtask

  // Random frames until the running byte count reaches stop_at.
  task automatic run_random(input int stop_at);
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 11))
        0: repeat ($urandom_range(1, 3)) send_byte(8'($urandom));  // may leave odd alignment
        1: begin
          send_word(cfg_swap);
          send_byte(8'($urandom));
        end
        2: drain_results();
        default: ;
      endcase
      send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4),
                 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, in-order field compare.
  // ---------------------------------------------------------------------------
  int         rx_stall = 0;
  parse_rec_t rx_got, rx_want;

  function automatic string fmt_rec(input parse_rec_t r);
    return $sformatf("kind=%0d sig=%h x=%h y=%h w=%h h=%h angle=%h cc=%0d ok=%0d count=%0d",
                     r.kind, r.sig, r.x, r.y, r.w, r.h, r.angle, r.cc, r.ok, r.count);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (pop && !empty) begin
        rx_got = {result_kind, signature, pos_x, pos_y, box_width, box_height, box_angle,
                  color_code, checksum_ok, good_count};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %s", fmt_rec(rx_got));
        end else begin
          rx_want = pending_results.pop_front();
          if (rx_got.kind !== rx_want.kind || rx_got.sig !== rx_want.sig ||
              rx_got.x !== rx_want.x || rx_got.y !== rx_want.y ||
              rx_got.w !== rx_want.w || rx_got.h !== rx_want.h ||
              rx_got.angle !== rx_want.angle || rx_got.cc !== rx_want.cc ||
              rx_got.ok !== rx_want.ok || rx_got.count !== rx_want.count) begin
            errors++;
            if (errors <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", fmt_rec(rx_want));
              $display("  actual   %s", fmt_rec(rx_got));
            end
          end
        end
      end
      if (rx_stall > 0) begin
        pop <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        pop <= 1'b1;
        rx_stall <= pick_gap(calm_rx);
      end
    end
  end

  // At regular intervals each side may switch to a stretch without gaps.
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 300 == 0) begin
      calm_tx <= ($urandom_range(0, 3) == 0);
      calm_rx <= ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: too long without a beat on any channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[camera_block_frame_parser_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    st = ST_HUNT;
    lo_byte = '0;
    hi_next = 1'b0;
    last_word = 16'hffff;
    fld_idx = '0;
    for (int i = 0; i < 6; i++) fld[i] = '0;
    acc_sum = '0;
    csum_word = '0;
    cc_mode = 1'b0;
    good_tally = '0;
    cfg_max = RST_MAX_BLOCKS;
    cfg_sync = RST_SYNC_WORD;
    cfg_sync_cc = RST_SYNC_WORD_CC;
    cfg_swap = RST_SYNC_SWAPPED;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, register reset values. Typed results where obvious.
    // zero pair right after reset: empty frame
    add_word(16'h0000);
    add_word(16'h0000, 1'b1, mk_end(8'd0));
    // swapped start word: next byte dropped to realign
    add_word(16'h55aa);
    add_row(8'h3c);
    // sync pair, then a normal block with extreme fields, good checksum
    add_word(16'haa55);
    add_word(16'haa55);
    add_word(16'hffff);
    add_word(16'hffff);
    add_word(16'hffff);
    add_word(16'h0000);
    add_word(16'h0001);
    add_word(16'h0000, 1'b1,
             mk_block(16'hffff, 16'hffff, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b1));
    // chain to a colour-code block with a bad checksum
    add_word(16'haa56);
    add_word(16'h0001);
    add_word(16'h8000);
    add_word(16'h8000);
    add_word(16'h0001);
    add_word(16'h0002);
    add_word(16'h0003);
    add_word(16'h0004, 1'b1,
             mk_block(16'h8000, 16'h8000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b1, 1'b0));
    // chain, then colour start word as checksum: frame ends, still in checksum
    add_word(16'haa55);
    add_word(16'haa56);
    // zero as checksum: empty frame, back to hunting
    add_word(16'h0000, 1'b1, mk_end(8'd0));
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    run_random(RANDOM_ITEMS * 1 / PHASES);

    // limit 1; zero start word collides with the zero-pair and zero-checksum tests
    set_config(16'd1, 16'h0000, 16'hffff, 16'h0001);
    run_random(RANDOM_ITEMS * 2 / PHASES);

    // limit 0 (junk in the upper bits), both start words equal
    set_config({8'($urandom), 8'd0}, 16'h1234, 16'h1234, 16'h3412);
    run_random(RANDOM_ITEMS * 3 / PHASES);

    // limit 2; start word equals the hunt's idle previous word and the swapped word
    set_config(16'd2, 16'hffff, 16'h0000, 16'hffff);
    run_random(RANDOM_ITEMS * 4 / PHASES);

    // limit 255 capped at 128
    set_config({8'($urandom), 8'hff}, RST_SYNC_WORD, RST_SYNC_WORD_CC, RST_SYNC_SWAPPED);
    run_random(RANDOM_ITEMS * 5 / PHASES);

    // back to limit 128, random start words
    begin
      logic [15:0] s;
      s = 16'($urandom);
      set_config(16'd128, s, 16'($urandom), {s[7:0], s[15:8]});
    end
    run_random(RANDOM_ITEMS * 6 / PHASES);

    go_idle();
    if (errors == 0)
      $display("[camera_block_frame_parser_top] OK");
    else
      $display("[camera_block_frame_parser_top] ERROR");
    $finish;
  end

endmodule
